/* hw/rtl/sfla_pkg.sv */
// sfla_pkg: shared types and codes for the slab free-list allocator
// transaction payload structs, operation kinds and status codes
// no dependencies
package sfla_pkg;

    localparam int ID_W   = 10;
    localparam int KIND_W = 2;
    localparam int ST_W   = 2;
    localparam int CNT_W  = 11;

    localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INIT  = 2'd2;

    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   slab_id;
    } t_in;

    typedef struct packed {
        logic [ID_W-1:0] granted_id;
        logic [ST_W-1:0] status;
    } t_out;

endpackage

/* hw/rtl/sfla_out_reg.sv */
// sfla_out_reg: output register stage between the allocator core and the result channel
// depends on sfla_pkg for the result struct
module sfla_out_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_res_valid,
    input  sfla_pkg::t_out i_res,
    output logic          o_slot_free,
    output logic          o_out_valid,
    output sfla_pkg::t_out o_out_data,
    input  logic          i_out_stall
);
    import sfla_pkg::*;

    logic r_valid;
    t_out r_data;

    assign o_slot_free = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_slot_free) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_slot_free && i_res_valid) begin
            r_data <= i_res;
        end
    end

endmodule

/* hw/rtl/sfla_core.sv */
// sfla_core: free-list head, slab count register, link memory and sequencer
// depends on sfla_pkg for payload structs and codes
module sfla_core #(
    parameter int MAX_SLABS = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [sfla_pkg::CNT_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    input  sfla_pkg::t_in               i_in_data,
    output logic                        o_in_stall,
    input  logic                        i_slot_free,
    output logic                        o_res_valid,
    output sfla_pkg::t_out              o_res
);
    import sfla_pkg::*;

    localparam int LW = $clog2(MAX_SLABS + 1);
    localparam int IW = $clog2(MAX_SLABS);
    localparam int NW = (LW > CNT_W) ? LW : CNT_W;
    localparam logic [LW-1:0] LINK_END = LW'(MAX_SLABS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ALLOC,
        S_INIT,
        S_HOLD
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [LW-1:0]     r_head;
    logic [LW-1:0]     n_head;
    logic [CNT_W-1:0]  r_pool_cnt;
    logic [IW-1:0]     r_idx;
    logic [IW-1:0]     r_last;
    t_out              r_res;

    logic [LW-1:0]     r_mem [MAX_SLABS];
    logic [LW-1:0]     r_rdata;

    logic [NW-1:0]     w_n;
    logic              w_accept;
    logic              w_done;
    t_out              w_res;
    logic              w_we;
    logic [IW-1:0]     w_waddr;
    logic [LW-1:0]     w_wdata;
    logic              w_re;
    logic [IW-1:0]     w_raddr;

    // count clamped to pool size
    assign w_n = (NW'(r_pool_cnt) > NW'(MAX_SLABS)) ? NW'(MAX_SLABS) : NW'(r_pool_cnt);
    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign o_res_valid = w_done && i_slot_free;
    assign o_res = w_res;

    always_comb begin
        w_done  = 1'b0;
        w_res   = '{granted_id: '0, status: ST_DONE};
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = (r_idx == r_last) ? LINK_END : (LW'(r_idx) + LW'(1));
        w_re    = 1'b0;
        w_raddr = r_head[IW-1:0];
        n_head  = r_head;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_in_data.kind)
                        KIND_ALLOC: begin
                            if (r_head >= LINK_END) begin
                                w_res.status = ST_EMPTY;
                                w_done = 1'b1;
                            end else begin
                                w_re = 1'b1;
                                n_state = S_ALLOC;
                            end
                        end
                        KIND_FREE: begin
                            if (NW'(i_in_data.slab_id) >= w_n) begin
                                w_res.status = ST_RANGE;
                            end else begin
                                w_we = 1'b1;
                                w_waddr = IW'(i_in_data.slab_id);
                                w_wdata = r_head;
                                n_head = LW'(i_in_data.slab_id);
                            end
                            w_done = 1'b1;
                        end
                        KIND_INIT: begin
                            if (w_n == '0) begin
                                w_done = 1'b1;
                            end else begin
                                n_state = S_INIT;
                            end
                        end
                        default: begin
                            w_done = 1'b1;
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                w_res.granted_id = ID_W'(r_head);
                n_head = r_rdata;
                w_done = 1'b1;
            end
            S_INIT: begin
                w_we = 1'b1;
                if (r_idx == r_last) begin
                    n_head = '0;
                    w_done = 1'b1;
                end
            end
            S_HOLD: begin
                w_res = r_res;
                w_done = 1'b1;
            end
        endcase
        if (w_done) begin
            n_state = i_slot_free ? S_IDLE : S_HOLD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= LINK_END;
            r_pool_cnt <= CNT_RESET;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            if (i_cfg_valid) begin
                r_pool_cnt <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_idx  <= '0;
            r_last <= IW'(w_n - NW'(1));
        end else if (r_state == S_INIT) begin
            r_idx <= r_idx + IW'(1);
        end
        if (w_done && !i_slot_free) begin
            r_res <= w_res;
        end
    end

    // link memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

`ifndef SYNTHESIS
    a_hold_after_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD && $past(r_state) != S_HOLD) |-> $past(!i_slot_free))
        else $error("result held without output stall");

    a_alloc_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.kind == KIND_ALLOC && r_head < LINK_END)
        |=> (r_state == S_ALLOC))
        else $error("allocate with nonempty pool did not read link");

    a_init_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT && r_idx == r_last) |=> (r_head == LW'(0)))
        else $error("head not at slab zero after init");
`endif

endmodule

/* hw/rtl/slab_free_list_allocator.sv */
// slab_free_list_allocator: LIFO free list of fixed-size slabs, top level
// free and empty allocate finish in S_IDLE; other allocates finish in S_ALLOC
// init writes the links of n slabs in S_INIT, one link memory write per cycle
// a transaction is taken only in S_IDLE; output register holds one waiting result
// reset: pool empty, slab count 1024, output empty; link memory is not cleared
// depends on sfla_pkg, sfla_core, sfla_out_reg
module slab_free_list_allocator #(
    parameter int MAX_SLABS = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [sfla_pkg::CNT_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  sfla_pkg::t_in               i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output sfla_pkg::t_out              o_out_data
);
    import sfla_pkg::*;

    logic w_slot_free;
    logic w_res_valid;
    t_out w_res;

    assign o_cfg_ready = 1'b1;

    sfla_core #(
        .MAX_SLABS(MAX_SLABS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_slot_free (w_slot_free),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    sfla_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_slot_free (w_slot_free),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
